### rtl/bdpc_pkg.sv
// ----------------------------------------------------------------------------
// bdpc_pkg
// Shared types and constants of the button debounce and press classifier.
// ----------------------------------------------------------------------------
package bdpc_pkg;

	localparam int TickW = 32;
	localparam int CfgW  = 16;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_DEBOUNCE_MS   = 1'b0,
		REG_LONG_PRESS_MS = 1'b1
	} cfg_reg_t;

	localparam logic [CfgW-1:0] DebounceReset  = 16'd20;
	localparam logic [CfgW-1:0] LongPressReset = 16'd1000;

	// latched event codes
	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_PRESSED  = 3'd1,
		EV_LONG     = 3'd2,
		EV_SHORT    = 3'd3,
		EV_RELEASED = 3'd4
	} event_t;

	typedef struct packed {
		logic             raw_pressed;
		logic [TickW-1:0] now_tick;
		logic             take_event;
	} item_t;

	typedef struct packed {
		event_t pending_event;
		logic   stable_pressed;
	} result_t;

endpackage

### rtl/bdpc_if.sv
// ----------------------------------------------------------------------------
// bdpc_item_if / bdpc_result_if
// Valid/ready channels for update items and result items.
// ----------------------------------------------------------------------------
interface bdpc_item_if;
	logic                      valid;
	logic                      ready;
	logic                      raw_pressed;
	logic [bdpc_pkg::TickW-1:0] now_tick;
	logic                      take_event;

	modport source (output valid, output raw_pressed, output now_tick, output take_event,
		input ready);
	modport sink (input valid, input raw_pressed, input now_tick, input take_event,
		output ready);
endinterface

interface bdpc_result_if;
	logic       valid;
	logic       ready;
	logic [2:0] pending_event;
	logic       stable_pressed;

	modport source (output valid, output pending_event, output stable_pressed, input ready);
	modport sink (input valid, input pending_event, input stable_pressed, output ready);
endinterface

### rtl/bdpc_core.sv
// ----------------------------------------------------------------------------
// bdpc_core
// Debounce and press classification state with its one-step update logic.
// ----------------------------------------------------------------------------
module bdpc_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  bdpc_pkg::item_t               item,
	input  logic [bdpc_pkg::CfgW-1:0]     debounce_ms,
	input  logic [bdpc_pkg::CfgW-1:0]     long_press_ms,
	output bdpc_pkg::result_t             result
);

	logic                         last_raw_q;
	logic [bdpc_pkg::TickW-1:0]   change_time_q;
	logic                         stable_q;
	logic [bdpc_pkg::TickW-1:0]   press_time_q;
	logic                         long_fired_q;
	bdpc_pkg::event_t             latched_q;

	logic                         raw_chg;
	logic [bdpc_pkg::TickW-1:0]   change_time_n;
	logic [bdpc_pkg::TickW-1:0]   db_elapsed;
	logic                         flip;
	logic                         stable_n;
	logic [bdpc_pkg::TickW-1:0]   press_time_n;
	logic [bdpc_pkg::TickW-1:0]   hold_elapsed;
	logic                         long_mid;
	logic                         long_hit;
	logic                         long_fired_n;
	bdpc_pkg::event_t             ev_mid;
	bdpc_pkg::event_t             ev_rep;

	// debounce: raw change restarts the timer, steady level moves the stable level
	always_comb begin
		raw_chg       = item.raw_pressed != last_raw_q;
		change_time_n = raw_chg ? item.now_tick : change_time_q;
		db_elapsed    = item.now_tick - change_time_n;
		flip          = (db_elapsed >= {{(bdpc_pkg::TickW-bdpc_pkg::CfgW){1'b0}}, debounce_ms})
			&& (stable_q != item.raw_pressed);
		stable_n      = flip ? item.raw_pressed : stable_q;
		press_time_n  = (flip && item.raw_pressed) ? item.now_tick : press_time_q;
		long_mid      = flip ? 1'b0 : long_fired_q;
		if (!flip) begin
			ev_mid = latched_q;
		end else if (item.raw_pressed) begin
			ev_mid = bdpc_pkg::EV_PRESSED;
		end else if (long_fired_q) begin
			ev_mid = bdpc_pkg::EV_RELEASED;
		end else begin
			ev_mid = bdpc_pkg::EV_SHORT;
		end
	end

	// long press detection on the updated state
	always_comb begin
		hold_elapsed = item.now_tick - press_time_n;
		long_hit     = stable_n && !long_mid
			&& (hold_elapsed >= {{(bdpc_pkg::TickW-bdpc_pkg::CfgW){1'b0}}, long_press_ms});
		long_fired_n = long_hit | long_mid;
		ev_rep       = long_hit ? bdpc_pkg::EV_LONG : ev_mid;
	end

	assign result.pending_event  = ev_rep;
	assign result.stable_pressed = stable_n;

	// state update, one item per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_raw_q    <= 1'b0;
			change_time_q <= '0;
			stable_q      <= 1'b0;
			press_time_q  <= '0;
			long_fired_q  <= 1'b0;
			latched_q     <= bdpc_pkg::EV_NONE;
		end else if (step) begin
			last_raw_q    <= item.raw_pressed;
			change_time_q <= change_time_n;
			stable_q      <= stable_n;
			press_time_q  <= press_time_n;
			long_fired_q  <= long_fired_n;
			latched_q     <= item.take_event ? bdpc_pkg::EV_NONE : ev_rep;
		end
	end

endmodule

### rtl/button_debounce_press_classifier.sv
// ----------------------------------------------------------------------------
// button_debounce_press_classifier
// Debounces a raw button level and classifies presses into events.
// ----------------------------------------------------------------------------
// Each update item gives exactly one result item. An item is captured in an
// input register, the state update runs on it as it moves on, and the result
// is captured in an output register; an item waits while the output register
// holds a result that is not taken. One item per clock is sustained while the
// result side does not stall: the single state update between input and
// output register sets the rate, and a result-side stall backs up into the
// input side. Configuration writes take effect at the next update.
module button_debounce_press_classifier (
	input  logic                      clk,
	input  logic                      arst_n,
	bdpc_item_if.sink                 item_in,
	bdpc_result_if.source             result_out,
	input  logic                      cfg_we,
	input  logic [0:0]                cfg_index,
	input  logic [bdpc_pkg::CfgW-1:0] cfg_wdata
);

	logic [bdpc_pkg::CfgW-1:0] debounce_q;
	logic [bdpc_pkg::CfgW-1:0] long_press_q;

	logic              valid_s1;
	bdpc_pkg::item_t   item_s1;
	logic              valid_s2;
	bdpc_pkg::result_t result_s2;
	bdpc_pkg::result_t result_n;
	logic              advance;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bdpc_pkg::DebounceReset;
			long_press_q <= bdpc_pkg::LongPressReset;
		end else if (cfg_we) begin
			unique case (bdpc_pkg::cfg_reg_t'(cfg_index))
				bdpc_pkg::REG_DEBOUNCE_MS:   debounce_q   <= cfg_wdata;
				bdpc_pkg::REG_LONG_PRESS_MS: long_press_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// handshake: stage 1 moves on when the output register is free or being taken
	assign advance       = valid_s1 && (!valid_s2 || result_out.ready);
	assign item_in.ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_in.ready) begin
			valid_s1 <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_in.valid && item_in.ready) begin
			item_s1.raw_pressed <= item_in.raw_pressed;
			item_s1.now_tick    <= item_in.now_tick;
			item_s1.take_event  <= item_in.take_event;
		end
	end

	bdpc_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.item          (item_s1),
		.debounce_ms   (debounce_q),
		.long_press_ms (long_press_q),
		.result        (result_n)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result_out.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_n;
		end
	end

	assign result_out.valid          = valid_s2;
	assign result_out.pending_event  = result_s2.pending_event;
	assign result_out.stable_pressed = result_s2.stable_pressed;

endmodule

### rtl/bdpc_checker.sv
// ----------------------------------------------------------------------------
// bdpc_checker
// Port-level checks on the result channel of the press classifier.
// ----------------------------------------------------------------------------
module bdpc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] out_event,
	input logic       out_stable
);

	// a stalled item stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result valid dropped while stalled");

	// a stalled item keeps its payload
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_event) && $stable(out_stable))
		else $error("result payload changed while stalled");

	// event code stays within the defined codes
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_event <= 3'(bdpc_pkg::EV_RELEASED)))
		else $error("undefined event code");

	// press events only while the stable level is pressed
	a_press_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_event == 3'(bdpc_pkg::EV_PRESSED)
			|| out_event == 3'(bdpc_pkg::EV_LONG)) |-> out_stable)
		else $error("press event with released level");

	// release events only while the stable level is released
	a_release_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_event == 3'(bdpc_pkg::EV_SHORT)
			|| out_event == 3'(bdpc_pkg::EV_RELEASED)) |-> !out_stable)
		else $error("release event with pressed level");

endmodule

bind button_debounce_press_classifier bdpc_checker u_bdpc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (result_out.valid),
	.out_ready  (result_out.ready),
	.out_event  (result_out.pending_event),
	.out_stable (result_out.stable_pressed)
);
